/* rtl/etcm_pkg.sv */
// Shared types, register indexes, request codes and angle constants for the thrust curve model.
`default_nettype none
package etcm_pkg;

    typedef enum logic [4:0] {
        S_IDLE, S_RANGE, S_RD, S_CMP, S_RD0, S_PREV, S_MUL, S_DIV, S_DIVW,
        S_ANG, S_CW1, S_CW2, S_FLOW, S_FW, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_GIMBAL = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    localparam logic [2:0] CFG_BURN     = 3'd0;
    localparam logic [2:0] CFG_EXHAUST  = 3'd1;
    localparam logic [2:0] CFG_POINTS   = 3'd2;
    localparam logic [2:0] CFG_GIM_LOW  = 3'd3;
    localparam logic [2:0] CFG_GIM_HIGH = 3'd4;
    localparam logic [2:0] CFG_MNT_POL  = 3'd5;
    localparam logic [2:0] CFG_MNT_AZI  = 3'd6;

    localparam logic signed [17:0] ANG_PI      = 18'sd25736;
    localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
    localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043837;
            5'd3:  r = 30'd133525159;
            5'd4:  r = 30'd67021687;
            5'd5:  r = 30'd33543516;
            5'd6:  r = 30'd16775851;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194283;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048576;
            5'd11: r = 30'd524288;
            5'd12: r = 30'd262144;
            5'd13: r = 30'd131072;
            5'd14: r = 30'd65536;
            5'd15: r = 30'd32768;
            5'd16: r = 30'd16384;
            5'd17: r = 30'd8192;
            5'd18: r = 30'd4096;
            5'd19: r = 30'd2048;
            5'd20: r = 30'd1024;
            5'd21: r = 30'd512;
            5'd22: r = 30'd256;
            5'd23: r = 30'd128;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/etcm_curve_mem.sv */
// Thrust curve point memory with one write port and one registered read port.
`default_nettype none
module etcm_curve_mem #(
    parameter int DEPTH = 32,
    parameter int IW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [31:0]   i_wtime,
    input  wire logic [30:0]   i_wthrust,
    input  wire logic [IW-1:0] i_raddr,
    output logic      [31:0]   o_rtime,
    output logic      [30:0]   o_rthrust
);
    logic [62:0] r_mem [DEPTH];
    logic [62:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wthrust, i_wtime};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rtime   = r_rd[31:0];
    assign o_rthrust = r_rd[62:32];
endmodule
`default_nettype wire

/* rtl/etcm_div.sv */
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module etcm_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic      [63:0] o_quotient,
    output logic             o_done
);
    logic        r_run, n_run;
    logic        r_done, n_done;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [32:0] rem_sh;

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        rem_sh = {r_rem[31:0], r_q[63]};
        if (i_start) begin
            n_run = 1'b1;
            n_cnt = 7'd0;
            n_q   = i_dividend;
            n_rem = 33'd0;
            n_den = i_divisor;
        end else if (r_run) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sh - {1'b0, r_den};
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_q   = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;
endmodule
`default_nettype wire

/* rtl/etcm_cordic.sv */
// Iterative rotation CORDIC that returns sine and cosine of a Q3.13 angle in Q1.13.
`default_nettype none
module etcm_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [16:0] i_angle,
    output logic signed      [14:0] o_sin,
    output logic signed      [14:0] o_cos,
    output logic                    o_done
);
    localparam int NS = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    logic               r_run, r_fin, r_done, r_neg;
    logic [4:0]         r_cnt;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic signed [14:0] r_sin, r_cos;

    logic signed [17:0] a_red, a_fold;
    logic               neg0;
    logic signed [33:0] dx, dy, fx, fy;
    logic signed [32:0] at;

    function automatic logic signed [14:0] to_q13(input logic signed [33:0] v);
        logic signed [34:0] w;
        logic signed [17:0] r;
        w = 35'(v) + 35'sd65536;
        r = 18'(w >>> 17);
        if (r > 18'sd8192) begin
            r = 18'sd8192;
        end else if (r < -18'sd8192) begin
            r = -18'sd8192;
        end
        return 15'(r);
    endfunction

    always_comb begin
        a_red = 18'(i_angle);
        if (a_red > etcm_pkg::ANG_PI) begin
            a_red = a_red - etcm_pkg::ANG_TWO_PI;
        end else if (a_red < -etcm_pkg::ANG_PI) begin
            a_red = a_red + etcm_pkg::ANG_TWO_PI;
        end
        a_fold = a_red;
        neg0   = 1'b0;
        if (a_red > etcm_pkg::ANG_HALF_PI) begin
            a_fold = a_red - etcm_pkg::ANG_PI;
            neg0   = 1'b1;
        end else if (a_red < -etcm_pkg::ANG_HALF_PI) begin
            a_fold = a_red + etcm_pkg::ANG_PI;
            neg0   = 1'b1;
        end
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        at = 33'({3'b000, etcm_pkg::atan_q30(r_cnt)});
        fx = r_neg ? -r_x : r_x;
        fy = r_neg ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 5'(NS - 1)) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
        if (i_start) begin
            r_cnt <= 5'd0;
            r_neg <= neg0;
            r_x   <= etcm_pkg::CORDIC_GAIN;
            r_y   <= 34'sd0;
            r_z   <= 33'(a_fold) <<< 17;
        end else if (r_run) begin
            r_cnt <= r_cnt + 5'd1;
            if (!r_z[32]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
        if (r_fin) begin
            r_sin <= to_q13(fy);
            r_cos <= to_q13(fx);
        end
    end

    assign o_sin  = r_sin;
    assign o_cos  = r_cos;
    assign o_done = r_done;
endmodule
`default_nettype wire

/* rtl/engine_thrust_curve_model.sv */
// Top level of the thrust curve model: sequencer, configuration and shared multiplier.
// Load is taken in the idle state alone. Update: a burn check, a search over the curve points, a read
// of the segment start, the interpolation product and divide, sine and cosine from the CORDIC,
// the mass flow divide, and the components and output.
// No transfer is taken meanwhile, and a stalled result holds the block in its output state.
// Synchronous active-low reset returns control state, configuration and the gimbal angles to their reset values.
`default_nettype none
module engine_thrust_curve_model #(
    parameter int CURVE_POINTS  = 32,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // point_index, point_time, point_thrust, sim_time, polar_command, azimuth_command
    input  wire logic [135:0] i_s_tdata,
    // req_type
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // thrust_magnitude, thrust_x, thrust_y, thrust_z, mass_flow
    output logic [159:0]      o_m_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    localparam int IW = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
    localparam int CW = $clog2(CURVE_POINTS + 1);

    etcm_pkg::t_state r_state, n_state;

    logic [31:0]        r_burn;
    logic [15:0]        r_ev;
    logic [5:0]         r_pts;
    logic signed [15:0] r_glow, r_ghigh, r_mpol, r_mazi, r_gpol, r_gazi;
    logic signed [15:0] cl_pol, cl_azi;

    logic [31:0]        r_t, r_t1, r_off, r_span, r_flow;
    logic [30:0]        r_y1, r_y0, r_dy, r_mag;
    logic               r_up;
    logic [CW-1:0]      r_idx;
    logic signed [14:0] r_sp, r_cp, r_sa, r_ca;
    logic signed [65:0] r_prod;
    logic [31:0]        r_x, r_y, r_z;
    logic               r_m_valid;
    logic [159:0]       r_m_data;

    logic               s_acc;
    logic [1:0]         req;
    logic [4:0]         f_idx;
    logic signed [15:0] f_pol, f_azi;
    logic               mem_we;
    logic [31:0]        rd_time;
    logic [30:0]        rd_thr;
    logic [8:0]         pin9, n9;
    logic [CW-1:0]      n_pts;

    logic               div_start, div_done, cor_start, cor_done;
    logic [63:0]        div_dvd, div_q;
    logic [31:0]        div_den;
    logic signed [16:0] cor_ang;
    logic signed [14:0] cor_sin, cor_cos;
    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p, p_sh;
    logic [31:0]        comp;

    assign req   = i_s_tuser;
    assign f_idx = i_s_tdata[4:0];
    assign f_pol = i_s_tdata[115:100];
    assign f_azi = i_s_tdata[131:116];
    assign o_s_tready = (r_state == etcm_pkg::S_IDLE);
    assign s_acc = i_s_tvalid && o_s_tready;
    assign mem_we = s_acc && req == etcm_pkg::REQ_LOAD
                    && ({4'b0000, f_idx} < 9'(CURVE_POINTS));

    etcm_curve_mem #(.DEPTH(CURVE_POINTS), .IW(IW)) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (IW'(f_idx)),
        .i_wtime   (i_s_tdata[36:5]),
        .i_wthrust (i_s_tdata[67:37]),
        .i_raddr   (r_idx[IW-1:0]),
        .o_rtime   (rd_time),
        .o_rthrust (rd_thr)
    );

    etcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_den),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    etcm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_ang),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos),
        .o_done  (cor_done)
    );

    always_comb begin
        cl_pol = f_pol;
        if (cl_pol < r_glow) cl_pol = r_glow;
        if (cl_pol > r_ghigh) cl_pol = r_ghigh;
        cl_azi = f_azi;
        if (cl_azi < r_glow) cl_azi = r_glow;
        if (cl_azi > r_ghigh) cl_azi = r_ghigh;
        pin9 = {3'b000, r_pts};
        if (pin9 < 9'd2) begin
            n9 = 9'd2;
        end else if (pin9 > 9'(CURVE_POINTS)) begin
            n9 = 9'(CURVE_POINTS);
        end else begin
            n9 = pin9;
        end
        n_pts = CW'(n9);
        p_sh = r_prod >>> 26;
        if (p_sh > 66'sd2147483647) begin
            comp = 32'h7FFF_FFFF;
        end else if (p_sh < -66'sd2147483648) begin
            comp = 32'h8000_0000;
        end else begin
            comp = p_sh[31:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_dvd   = r_prod[63:0];
        div_den   = r_span;
        cor_start = 1'b0;
        cor_ang   = {r_gpol[15], r_gpol} + {r_mpol[15], r_mpol};
        m_a       = 33'({2'b00, r_mag});
        m_b       = r_prod[32:0];
        case (r_state)
            etcm_pkg::S_IDLE: begin
                if (s_acc && (req == etcm_pkg::REQ_UPDATE || req == etcm_pkg::REQ_GIMBAL)) begin
                    n_state = etcm_pkg::S_RANGE;
                end
            end
            etcm_pkg::S_RANGE: begin
                n_state = (r_t > r_burn) ? etcm_pkg::S_ANG : etcm_pkg::S_RD;
            end
            etcm_pkg::S_RD: n_state = etcm_pkg::S_CMP;
            etcm_pkg::S_CMP: begin
                if (rd_time >= r_t) begin
                    n_state = etcm_pkg::S_RD0;
                end else if (r_idx + CW'(1) == n_pts) begin
                    n_state = etcm_pkg::S_ANG;
                end else begin
                    n_state = etcm_pkg::S_RD;
                end
            end
            etcm_pkg::S_RD0: n_state = etcm_pkg::S_PREV;
            etcm_pkg::S_PREV: begin
                n_state = (r_t <= rd_time) ? etcm_pkg::S_ANG : etcm_pkg::S_MUL;
            end
            etcm_pkg::S_MUL: begin
                m_a     = 33'({2'b00, r_dy});
                m_b     = 33'({1'b0, r_off});
                n_state = etcm_pkg::S_DIV;
            end
            etcm_pkg::S_DIV: begin
                div_start = 1'b1;
                n_state   = etcm_pkg::S_DIVW;
            end
            etcm_pkg::S_DIVW: begin
                if (div_done) n_state = etcm_pkg::S_ANG;
            end
            etcm_pkg::S_ANG: begin
                cor_start = 1'b1;
                n_state   = etcm_pkg::S_CW1;
            end
            etcm_pkg::S_CW1: begin
                cor_ang = {r_gazi[15], r_gazi} + {r_mazi[15], r_mazi};
                if (cor_done) begin
                    cor_start = 1'b1;
                    n_state   = etcm_pkg::S_CW2;
                end
            end
            etcm_pkg::S_CW2: begin
                if (cor_done) n_state = etcm_pkg::S_FLOW;
            end
            etcm_pkg::S_FLOW: begin
                div_dvd = 64'({r_mag, 8'h00});
                div_den = 32'(r_ev);
                if (r_ev == 16'd0) begin
                    n_state = etcm_pkg::S_M1;
                end else begin
                    div_start = 1'b1;
                    n_state   = etcm_pkg::S_FW;
                end
            end
            etcm_pkg::S_FW: begin
                if (div_done) n_state = etcm_pkg::S_M1;
            end
            etcm_pkg::S_M1: begin
                m_a     = 33'(r_sp);
                m_b     = 33'(r_ca);
                n_state = etcm_pkg::S_M2;
            end
            etcm_pkg::S_M2: n_state = etcm_pkg::S_M3;
            etcm_pkg::S_M3: begin
                m_a     = 33'(r_sp);
                m_b     = 33'(r_sa);
                n_state = etcm_pkg::S_M4;
            end
            etcm_pkg::S_M4: n_state = etcm_pkg::S_M5;
            etcm_pkg::S_M5: begin
                m_b     = 33'(r_cp) <<< 13;
                n_state = etcm_pkg::S_M6;
            end
            etcm_pkg::S_M6: n_state = etcm_pkg::S_OUT;
            etcm_pkg::S_OUT: begin
                if (!r_m_valid || i_m_tready) n_state = etcm_pkg::S_IDLE;
            end
            default: n_state = etcm_pkg::S_IDLE;
        endcase
        m_p = 66'(m_a) * 66'(m_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= etcm_pkg::S_IDLE;
            r_m_valid <= 1'b0;
            r_burn    <= 32'd0;
            r_ev      <= 16'd2452;
            r_pts     <= 6'd2;
            r_glow    <= 16'sd0;
            r_ghigh   <= 16'sd0;
            r_mpol    <= 16'sd0;
            r_mazi    <= 16'sd0;
            r_gpol    <= 16'sd0;
            r_gazi    <= 16'sd0;
        end else begin
            r_state <= n_state;
            if (r_state == etcm_pkg::S_OUT && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    etcm_pkg::CFG_BURN:     r_burn  <= i_cfg_data;
                    etcm_pkg::CFG_EXHAUST:  r_ev    <= i_cfg_data[15:0];
                    etcm_pkg::CFG_POINTS:   r_pts   <= i_cfg_data[5:0];
                    etcm_pkg::CFG_GIM_LOW:  r_glow  <= i_cfg_data[15:0];
                    etcm_pkg::CFG_GIM_HIGH: r_ghigh <= i_cfg_data[15:0];
                    etcm_pkg::CFG_MNT_POL:  r_mpol  <= i_cfg_data[15:0];
                    etcm_pkg::CFG_MNT_AZI:  r_mazi  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_acc && req == etcm_pkg::REQ_GIMBAL) begin
                r_gpol <= cl_pol;
                r_gazi <= cl_azi;
            end
        end

        r_prod <= m_p;
        case (r_state)
            etcm_pkg::S_IDLE: begin
                r_t   <= i_s_tdata[99:68];
                r_mag <= 31'd0;
            end
            etcm_pkg::S_RANGE: r_idx <= CW'(1);
            etcm_pkg::S_CMP: begin
                r_t1 <= rd_time;
                r_y1 <= rd_thr;
                if (rd_time >= r_t) begin
                    r_idx <= r_idx - CW'(1);
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            etcm_pkg::S_PREV: begin
                r_y0   <= rd_thr;
                r_mag  <= rd_thr;
                r_off  <= r_t - rd_time;
                r_span <= r_t1 - rd_time;
                r_up   <= (r_y1 >= rd_thr);
                r_dy   <= (r_y1 >= rd_thr) ? (r_y1 - rd_thr) : (rd_thr - r_y1);
            end
            etcm_pkg::S_DIVW: begin
                r_mag <= r_up ? (r_y0 + div_q[30:0]) : (r_y0 - div_q[30:0]);
            end
            etcm_pkg::S_CW1: begin
                if (cor_done) begin
                    r_sp <= cor_sin;
                    r_cp <= cor_cos;
                end
            end
            etcm_pkg::S_CW2: begin
                r_sa <= cor_sin;
                r_ca <= cor_cos;
            end
            etcm_pkg::S_FLOW: begin
                r_flow <= (r_mag != 31'd0) ? 32'hFFFF_FFFF : 32'd0;
            end
            etcm_pkg::S_FW: begin
                r_flow <= (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
            end
            etcm_pkg::S_M3: r_x <= comp;
            etcm_pkg::S_M5: r_y <= comp;
            etcm_pkg::S_M6: r_z <= comp;
            etcm_pkg::S_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    r_m_data <= {1'b0, r_flow, r_z, r_y, r_x, r_mag};
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_update_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (req == etcm_pkg::REQ_UPDATE || req == etcm_pkg::REQ_GIMBAL)
        |=> r_state == etcm_pkg::S_RANGE)
        else $error("update transfer did not start the sequencer");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == etcm_pkg::S_DIVW || r_state == etcm_pkg::S_FW))
        else $error("divider finished outside a divide wait state");

    a_cordic_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_done |-> (r_state == etcm_pkg::S_CW1 || r_state == etcm_pkg::S_CW2))
        else $error("CORDIC finished outside an angle wait state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == etcm_pkg::S_OUT && r_m_valid && !i_m_tready
        |=> r_state == etcm_pkg::S_OUT && $stable(r_m_data))
        else $error("pending result overwritten");
endmodule
`default_nettype wire

/* bench/engine_thrust_curve_model_tb.sv */
// Self-checking testbench for the thrust curve model: curve loads, updates and gimbal commands.
`default_nettype none
module engine_thrust_curve_model_tb;

    typedef struct {
        logic [30:0]        mag;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic [31:0]        flow;
    } t_thrust;

    typedef struct {
        etcm_pkg::t_req     req;
        logic [4:0]         idx;
        logic [31:0]        ptime;
        logic [30:0]        pthrust;
        logic [31:0]        stime;
        logic signed [15:0] pol_cmd;
        logic signed [15:0] azi_cmd;
    } t_request;

    class thrust_scoreboard;
        logic [31:0] times [32];
        logic [30:0] thrusts [32];
        int gim_pol, gim_azi;
        logic [31:0] burn;
        int unsigned exh_vel, pts;
        int lim_lo, lim_hi, mnt_pol, mnt_azi;
        t_thrust pending[$];
        int errors;

        function void clear();
            gim_pol = 0; gim_azi = 0; burn = 0; exh_vel = 2452; pts = 2;
            lim_lo = 0; lim_hi = 0; mnt_pol = 0; mnt_azi = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                etcm_pkg::CFG_BURN:     burn = val;
                etcm_pkg::CFG_EXHAUST:  exh_vel = val[15:0];
                etcm_pkg::CFG_POINTS:   pts = val[5:0];
                etcm_pkg::CFG_GIM_LOW:  lim_lo = $signed(val[15:0]);
                etcm_pkg::CFG_GIM_HIGH: lim_hi = $signed(val[15:0]);
                etcm_pkg::CFG_MNT_POL:  mnt_pol = $signed(val[15:0]);
                etcm_pkg::CFG_MNT_AZI:  mnt_azi = $signed(val[15:0]);
                default: ;
            endcase
        endfunction

        function longint unsigned thrust_at(logic [31:0] t);
            int unsigned n;
            longint unsigned y0, y1, off, span;
            n = pts;
            if (t > burn) return 0;
            if (n < 2) n = 2;
            if (n > 32) n = 32;
            for (int i = 1; i < n; i++) begin
                if (times[i] >= t) begin
                    if (t <= times[i-1]) return thrusts[i-1];
                    y0 = thrusts[i-1];
                    y1 = thrusts[i];
                    off = t - times[i-1];
                    span = times[i] - times[i-1];
                    if (y1 >= y0) return y0 + (y1 - y0) * off / span;
                    return y0 - (y0 - y1) * off / span;
                end
            end
            return 0;
        endfunction

        function longint to_q13(longint v);
            longint r;
            r = (v + 65536) >>> 17;
            if (r > 8192) r = 8192;
            if (r < -8192) r = -8192;
            return r;
        endfunction

        function void sin_cos(int ang, output longint s, output longint c);
            longint x, y, z, dx, dy;
            bit flip;
            x = etcm_pkg::CORDIC_GAIN; y = 0; flip = 0;
            while (ang > etcm_pkg::ANG_PI) ang -= etcm_pkg::ANG_TWO_PI;
            while (ang < -etcm_pkg::ANG_PI) ang += etcm_pkg::ANG_TWO_PI;
            if (ang > etcm_pkg::ANG_HALF_PI) begin
                ang -= etcm_pkg::ANG_PI; flip = 1;
            end else if (ang < -etcm_pkg::ANG_HALF_PI) begin
                ang += etcm_pkg::ANG_PI; flip = 1;
            end
            z = longint'(ang) * 131072;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(etcm_pkg::atan_q30(5'(i)));
                end else begin
                    x += dx; y -= dy; z += longint'(etcm_pkg::atan_q30(5'(i)));
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            s = to_q13(y);
            c = to_q13(x);
        endfunction

        function logic [31:0] axis(longint m, longint a, longint b);
            longint v;
            v = (m * a * b) >>> 26;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function int limit_angle(int v);
            if (v < lim_lo) v = lim_lo;
            if (v > lim_hi) v = lim_hi;
            return v;
        endfunction

        function void note_request(t_request r);
            t_thrust e;
            longint unsigned m, f;
            longint sp, cp, sa, ca;
            if (r.req == etcm_pkg::REQ_LOAD) begin
                times[r.idx] = r.ptime;
                thrusts[r.idx] = r.pthrust;
                return;
            end
            if (r.req == etcm_pkg::REQ_NONE) return;
            if (r.req == etcm_pkg::REQ_GIMBAL) begin
                gim_pol = limit_angle(r.pol_cmd);
                gim_azi = limit_angle(r.azi_cmd);
            end
            m = thrust_at(r.stime);
            sin_cos(gim_pol + mnt_pol, sp, cp);
            sin_cos(gim_azi + mnt_azi, sa, ca);
            if (exh_vel == 0) f = (m != 0) ? 64'hFFFFFFFF : 0;
            else begin
                f = m * 256 / exh_vel;
                if (f > 64'hFFFFFFFF) f = 64'hFFFFFFFF;
            end
            e.mag = m[30:0];
            e.fx = axis(m, sp, ca);
            e.fy = axis(m, sp, sa);
            e.fz = axis(m, cp, 8192);
            e.flow = f[31:0];
            pending.push_back(e);
        endfunction

        function void check_result(logic [159:0] d);
            t_thrust e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[30:0] !== e.mag) begin
                $error("thrust_magnitude: expected %0d, got %0d", e.mag, d[30:0]); errors++;
            end
            if (d[62:31] !== e.fx) begin
                $error("thrust_x: expected %0d, got %0d", e.fx, $signed(d[62:31])); errors++;
            end
            if (d[94:63] !== e.fy) begin
                $error("thrust_y: expected %0d, got %0d", e.fy, $signed(d[94:63])); errors++;
            end
            if (d[126:95] !== e.fz) begin
                $error("thrust_z: expected %0d, got %0d", e.fz, $signed(d[126:95])); errors++;
            end
            if (d[158:127] !== e.flow) begin
                $error("mass_flow: expected %0d, got %0d", e.flow, d[158:127]); errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [135:0] i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [159:0] o_m_tdata;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    thrust_scoreboard sb;
    int burst_left;
    int unsigned results_seen;
    logic [31:0] curve_end;

    engine_thrust_curve_model dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver stalls at random, sometimes not at all, and now and then holds off
    // for a long stretch so that the block backs up onto its input.
    initial begin
        int hold, mode, span;
        hold = 0; mode = 0; span = 0;
        i_m_tready = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (results_seen % 130 == 65) hold = 1500;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(20, 400);
            end else span--;
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else if (mode == 0) i_m_tready <= 1'b1;
            else i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    task automatic send(t_request r);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= r.req;
        i_s_tdata <= {4'd0, r.azi_cmd, r.pol_cmd, r.stime, r.pthrust, r.ptime, r.idx};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(r);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_request rand_request(etcm_pkg::t_req kind);
        t_request r;
        r.req = kind;
        r.idx = 5'($urandom);
        r.ptime = $urandom;
        r.pthrust = 31'($urandom);
        r.stime = $urandom;
        r.pol_cmd = 16'($urandom);
        r.azi_cmd = 16'($urandom);
        return r;
    endfunction

    // Rewrites all points with ascending times; steps of zero give equal neighbors.
    task automatic load_curve(int unsigned step);
        t_request r;
        logic [31:0] t;
        t = $urandom_range(0, step);
        for (int i = 0; i < 32; i++) begin
            r = rand_request(etcm_pkg::REQ_LOAD);
            r.idx = 5'(i);
            r.ptime = t;
            if ($urandom_range(0, 3) == 0) r.pthrust = 31'($urandom_range(0, 100000));
            send(r);
            curve_end = t;
            t = t + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step));
        end
    endtask

    function automatic t_request rand_update();
        t_request r;
        int sel;
        sel = $urandom_range(0, 19);
        r = rand_request((sel < 10) ? etcm_pkg::REQ_UPDATE :
                         (sel < 19) ? etcm_pkg::REQ_GIMBAL : etcm_pkg::REQ_NONE);
        if ($urandom_range(0, 7) != 0)
            r.stime = $urandom_range(0, curve_end + curve_end / 8);
        if ($urandom_range(0, 1) == 0) begin
            r.pol_cmd = $signed(16'($urandom_range(0, 2 * 4000))) - 16'sd4000;
            r.azi_cmd = $signed(16'($urandom_range(0, 2 * 4000))) - 16'sd4000;
        end
        return r;
    endfunction

    initial begin
        t_request r;
        int lo, hi;
        sb = new();
        sb.clear();
        burst_left = 0;
        results_seen = 0;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = etcm_pkg::REQ_LOAD;
        i_cfg_we = 0;
        i_cfg_index = etcm_pkg::CFG_BURN;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: full-range settings, then point times and extremes of time and angle.
        load_curve(40000);
        drain();
        write_reg(etcm_pkg::CFG_BURN, 32'hFFFFFFFF);
        write_reg(etcm_pkg::CFG_POINTS, 32);
        write_reg(etcm_pkg::CFG_GIM_LOW, 32'hFFFF8000);
        write_reg(etcm_pkg::CFG_GIM_HIGH, 32'h00007FFF);
        foreach (sb.times[i]) if (i < 6) begin
            r = rand_request(etcm_pkg::REQ_UPDATE);
            r.stime = sb.times[i];
            send(r);
        end
        r = rand_request(etcm_pkg::REQ_UPDATE); r.stime = 0; send(r);
        r.stime = 32'hFFFFFFFF; send(r);
        r.stime = curve_end; send(r);
        r = rand_request(etcm_pkg::REQ_GIMBAL); r.stime = curve_end / 2;
        r.pol_cmd = 16'sh7FFF; r.azi_cmd = -16'sh8000; send(r);
        r.pol_cmd = -16'sh8000; r.azi_cmd = 16'sh7FFF; send(r);
        r.pol_cmd = 16'sd12868; r.azi_cmd = -16'sd12868; send(r);
        r.pol_cmd = 0; r.azi_cmd = 16'sd25736; send(r);
        r = rand_request(etcm_pkg::REQ_NONE); send(r);
        drain();

        for (int p = 0; p < 8; p++) begin
            load_curve((p % 2) ? 2000 : 1 << (8 + p * 2));
            drain();
            write_reg(etcm_pkg::CFG_BURN, (p == 1) ? 32'd0 : (p == 2) ? 32'hFFFFFFFF :
                                $urandom_range(0, curve_end + curve_end / 4));
            write_reg(etcm_pkg::CFG_EXHAUST, (p == 3) ? 32'd0 : (p == 4) ? 32'd65535 :
                                   (p == 5) ? 32'd1 : $urandom_range(1, 65535));
            write_reg(etcm_pkg::CFG_POINTS, (p == 6) ? 32'd63 : (p == 7) ? 32'd0 :
                                  (p == 1) ? 32'd1 : $urandom_range(2, 32));
            lo = $urandom_range(0, 6000);
            hi = $urandom_range(0, 6000);
            if (p == 2) begin
                lo = 32768; hi = 32767;
            end
            if (p == 4) begin
                lo = -2000; hi = -3000;
            end
            write_reg(etcm_pkg::CFG_GIM_LOW, -lo);
            write_reg(etcm_pkg::CFG_GIM_HIGH, (p == 4) ? hi : hi);
            write_reg(etcm_pkg::CFG_MNT_POL,
                      (p == 3) ? 32'h8000 : (p == 5) ? 32'h7FFF : $urandom);
            write_reg(etcm_pkg::CFG_MNT_AZI,
                      (p == 3) ? 32'h7FFF : (p == 5) ? 32'h8000 : $urandom);
            for (int k = 0; k < 45; k++) send(rand_update());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
rtl/etcm_pkg.sv
rtl/etcm_curve_mem.sv
rtl/etcm_div.sv
rtl/etcm_cordic.sv
rtl/engine_thrust_curve_model.sv
bench/engine_thrust_curve_model_tb.sv
